@@ rtl/utt_pkg.sv @@
// Shared types, constants and lead-byte decode for the UTF-8 to UTF-16 transcoder.
package utt_pkg;

    localparam logic [15:0] REPL_UNIT     = 16'hFFFD;
    localparam logic [5:0]  HIGH_SURR_TAG = 6'b110110;
    localparam logic [5:0]  LOW_SURR_TAG  = 6'b110111;
    localparam logic [1:0]  CONT_TAG      = 2'b10;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_string;
    } utt_item_t;

    typedef struct packed {
        logic      valid;
        utt_item_t item;
    } utt_queue_t;

    // Sequence length announced by a lead byte; zero for a byte that cannot lead.
    function automatic logic [2:0] seq_len(input logic [7:0] b);
        logic [2:0] n;
        priority if (b[7] == 1'b0)           n = 3'd1;
        else if (b[7:5] == 3'b110)           n = 3'd2;
        else if (b[7:4] == 4'b1110)          n = 3'd3;
        else if (b[7:3] == 5'b11110)         n = 3'd4;
        else                                 n = 3'd0;
        return n;
    endfunction

endpackage

@@ rtl/utt_front.sv @@
// Input side: accepts bytes into a two-entry queue ahead of the decoder.
module utt_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // data_byte
    input  logic              s_tlast,   // end_of_string
    input  logic              q_pop,
    output utt_pkg::utt_queue_t q_head
);
    import utt_pkg::*;

    utt_item_t  entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;
    logic       push;
    logic       pop;

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && (count_reg != 2'd0);

    assign q_head.valid = (count_reg != 2'd0);
    assign q_head.item  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= '{data_byte: s_tdata, end_of_string: s_tlast};
        end
    end

endmodule

@@ rtl/utt_back.sv @@
// Decoder: works through the held bytes one code unit per cycle into an output register, unless the output stalls.
module utt_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  utt_pkg::utt_queue_t q_head,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,   // code_unit
    output logic                m_tlast,   // last_of_run
    output logic                m_tuser    // string_done
);
    import utt_pkg::*;

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_LOW  = 2'd2;

    logic [1:0]  state_reg,  state_next;
    logic [7:0]  buf_reg [4];
    logic [7:0]  buf_next [4];
    logic [7:0]  sh_buf [4];
    logic [2:0]  len_reg,    len_next;
    logic        at_end_reg, at_end_next;
    logic [15:0] low_reg,    low_next;
    logic        more_reg,   more_next;

    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_unit_reg,  out_unit_next;
    logic        out_last_reg,  out_last_next;
    logic        out_done_reg,  out_done_next;

    logic        out_free;
    logic [2:0]  lead_need;
    logic        c1, c2, c3;
    logic [10:0] cp2;
    logic [15:0] cp3;
    logic [20:0] cp4;
    logic [20:0] cp4_off;
    logic        seq_ok;
    logic [2:0]  shift;
    logic [2:0]  len_after;
    logic [2:0]  next_need;
    logic        more;

    assign out_free = !out_valid_reg || m_tready;

    assign lead_need = seq_len(buf_reg[0]);
    assign c1 = (buf_reg[1][7:6] == CONT_TAG);
    assign c2 = (buf_reg[2][7:6] == CONT_TAG);
    assign c3 = (buf_reg[3][7:6] == CONT_TAG);
    assign cp2 = {buf_reg[0][4:0], buf_reg[1][5:0]};
    assign cp3 = {buf_reg[0][3:0], buf_reg[1][5:0], buf_reg[2][5:0]};
    assign cp4 = {buf_reg[0][2:0], buf_reg[1][5:0], buf_reg[2][5:0], buf_reg[3][5:0]};
    assign cp4_off = cp4 - 21'h010000;

    always_comb begin
        unique case (lead_need)
            3'd1:    seq_ok = 1'b1;
            3'd2:    seq_ok = c1 && (cp2 >= 11'h080);
            3'd3:    seq_ok = c1 && c2 && (cp3 >= 16'h0800) && (cp3[15:11] != 5'b11011);
            3'd4:    seq_ok = c1 && c2 && c3 && (cp4 >= 21'h010000) && (cp4 <= 21'h10FFFF);
            default: seq_ok = 1'b0;
        endcase
    end

    // Bytes consumed by this step: the whole sequence when it decodes, else the lead only.
    assign shift = (lead_need != 3'd0 && seq_ok) ? lead_need : 3'd1;

    always_comb begin
        sh_buf = buf_reg;
        unique case (shift)
            3'd1: begin
                sh_buf[0] = buf_reg[1];
                sh_buf[1] = buf_reg[2];
                sh_buf[2] = buf_reg[3];
            end
            3'd2: begin
                sh_buf[0] = buf_reg[2];
                sh_buf[1] = buf_reg[3];
            end
            3'd3: begin
                sh_buf[0] = buf_reg[3];
            end
            default: sh_buf = buf_reg;
        endcase
    end

    assign len_after = len_reg - shift;
    assign next_need = seq_len(sh_buf[0]);
    // Another unit follows unless the remainder is empty or only waits for more bytes.
    assign more = (len_after != 3'd0) &&
                  (at_end_reg || (next_need == 3'd0) || (next_need <= len_after));

    always_comb begin
        state_next     = state_reg;
        buf_next       = buf_reg;
        len_next       = len_reg;
        at_end_next    = at_end_reg;
        low_next       = low_reg;
        more_next      = more_reg;
        q_pop          = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        out_unit_next  = out_unit_reg;
        out_last_next  = out_last_reg;
        out_done_next  = out_done_reg;

        unique case (state_reg)
            ST_LOAD: begin
                if (q_head.valid) begin
                    q_pop = 1'b1;
                    unique case (len_reg[1:0])
                        2'd0:    buf_next[0] = q_head.item.data_byte;
                        2'd1:    buf_next[1] = q_head.item.data_byte;
                        2'd2:    buf_next[2] = q_head.item.data_byte;
                        default: buf_next[3] = q_head.item.data_byte;
                    endcase
                    len_next    = len_reg + 3'd1;
                    at_end_next = q_head.item.end_of_string;
                    state_next  = ST_RUN;
                end
            end
            ST_RUN: begin
                if (out_free) begin
                    if (lead_need != 3'd0 && lead_need > len_reg) begin
                        // Incomplete sequence: flush at end of string, else hold it.
                        if (at_end_reg) begin
                            out_valid_next = 1'b1;
                            out_unit_next  = REPL_UNIT;
                            out_last_next  = 1'b1;
                            out_done_next  = 1'b1;
                            len_next       = 3'd0;
                        end
                        state_next = ST_LOAD;
                    end else begin
                        out_valid_next = 1'b1;
                        buf_next       = sh_buf;
                        len_next       = len_after;
                        out_last_next  = !more;
                        out_done_next  = !more && at_end_reg;
                        state_next     = more ? ST_RUN : ST_LOAD;
                        if (lead_need == 3'd0 || !seq_ok) begin
                            out_unit_next = REPL_UNIT;
                        end else if (lead_need == 3'd4) begin
                            out_unit_next = {HIGH_SURR_TAG, cp4_off[19:10]};
                            out_last_next = 1'b0;
                            out_done_next = 1'b0;
                            low_next      = {LOW_SURR_TAG, cp4_off[9:0]};
                            more_next     = more;
                            state_next    = ST_LOW;
                        end else if (lead_need == 3'd3) begin
                            out_unit_next = cp3;
                        end else if (lead_need == 3'd2) begin
                            out_unit_next = {5'd0, cp2};
                        end else begin
                            out_unit_next = {8'd0, buf_reg[0]};
                        end
                    end
                end
            end
            ST_LOW: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_unit_next  = low_reg;
                    out_last_next  = !more_reg;
                    out_done_next  = !more_reg && at_end_reg;
                    state_next     = more_reg ? ST_RUN : ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            len_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg      <= buf_next;
        at_end_reg   <= at_end_next;
        low_reg      <= low_next;
        more_reg     <= more_next;
        out_unit_reg <= out_unit_next;
        out_last_reg <= out_last_next;
        out_done_reg <= out_done_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_unit_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_done_reg;

endmodule

@@ rtl/utf8_to_utf16_transcoder.sv @@
// Each byte is loaded from the queue in its own load step, followed by a decode step per code
// unit it releases (one step when it releases none); output stalls hold the decoder. It takes no
// new byte until it has released the code units that the last one completed.
// A two-entry input queue takes up to two bytes while the decoder works or the output stalls.
// Reset (aresetn low, synchronous) empties the queue and the hold and drops any pending unit.
module utf8_to_utf16_transcoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_string
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] code_unit
    output logic        m_tlast,   // last_of_run
    output logic        m_tuser    // [0] string_done
);
    import utt_pkg::*;

    utt_queue_t q_head;
    logic       q_pop;

    utt_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_pop    (q_pop),
        .q_head   (q_head)
    );

    utt_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTHESIS
    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("string_done without last_of_run");

    a_high_surr_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[15:10] == HIGH_SURR_TAG)) |-> !m_tlast)
        else $error("high surrogate closes a run");

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");
`endif

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the UTF-8 to UTF-16 transcoder: directed and random strings.
`timescale 1ns / 100ps

module tb;
    import utt_pkg::*;

    localparam int unsigned STALL_LIMIT = 5000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned BYTES_PER_PHASE = 34;
    localparam int unsigned PRESSURE_CYCLES = 80;

    typedef struct {
        logic [15:0] code;
        logic        last;
        logic        done;
    } unit_t;

    // Predicts the UTF-16 units each accepted byte releases and checks them in order.
    class unit_ledger;
        unit_t       expected_units[$];
        bit [7:0]    held[3];
        int unsigned held_count = 0;
        int unsigned errors = 0;

        function void note_byte(bit [7:0] data, bit eos);
            bit [7:0]    work[4];
            int unsigned len, pos, need, k, rest;
            bit [31:0]   cp, floor_cp;
            bit          ok;
            unit_t       fresh[$];
            for (k = 0; k < held_count; k++) work[k] = held[k];
            work[held_count] = data;
            len = held_count + 1;
            pos = 0;
            while (pos < len) begin
                if (work[pos][7] == 1'b0) begin
                    cp = 32'(work[pos]); need = 1; floor_cp = 32'h0;
                end else if (work[pos][7:5] == 3'b110) begin
                    cp = 32'(work[pos][4:0]); need = 2; floor_cp = 32'h80;
                end else if (work[pos][7:4] == 4'b1110) begin
                    cp = 32'(work[pos][3:0]); need = 3; floor_cp = 32'h800;
                end else if (work[pos][7:3] == 5'b11110) begin
                    cp = 32'(work[pos][2:0]); need = 4; floor_cp = 32'h10000;
                end else begin
                    // not a lead byte: replace and skip one byte
                    fresh.insert(fresh.size(), '{REPL_UNIT, 1'b0, 1'b0});
                    pos++;
                    continue;
                end
                if (pos + need > len) begin
                    // incomplete: one replacement at end of string, drop the rest; else hold it
                    if (eos) begin
                        fresh.insert(fresh.size(), '{REPL_UNIT, 1'b0, 1'b0});
                        pos = len;
                    end
                    break;
                end
                ok = 1'b1;
                for (k = 1; k < need; k++) begin
                    if (work[pos + k][7:6] != 2'b10) begin
                        ok = 1'b0;
                        break;
                    end
                    cp = {cp[25:0], work[pos + k][5:0]};
                end
                if (!ok || cp < floor_cp || cp > 32'h10FFFF ||
                    (cp >= 32'hD800 && cp <= 32'hDFFF)) begin
                    fresh.insert(fresh.size(), '{REPL_UNIT, 1'b0, 1'b0});
                    pos++;
                    continue;
                end
                if (cp <= 32'hFFFF) begin
                    fresh.insert(fresh.size(), '{cp[15:0], 1'b0, 1'b0});
                end else begin
                    cp = cp - 32'h10000;
                    fresh.insert(fresh.size(), '{16'hD800 + cp[19:10], 1'b0, 1'b0});
                    fresh.insert(fresh.size(), '{16'hDC00 + cp[9:0], 1'b0, 1'b0});
                end
                pos += need;
            end
            rest = eos ? 0 : len - pos;
            for (k = 0; k < rest; k++) held[k] = work[pos + k];
            held_count = rest;
            if (fresh.size() > 0) begin
                fresh[fresh.size() - 1].last = 1'b1;
                fresh[fresh.size() - 1].done = eos;
            end
            expected_units = {expected_units, fresh};
        endfunction

        function void check_unit(logic [15:0] code, logic last, logic done);
            unit_t want;
            if (expected_units.size() == 0) begin
                errors++;
                $display("%0t: unexpected unit expected none actual %h/%b/%b",
                         $time, code, last, done);
                return;
            end
            want = expected_units.pop_front();
            if (want.code !== code) begin
                errors++;
                $display("%0t: code_unit expected %h actual %h", $time, want.code, code);
            end
            if (want.last !== last) begin
                errors++;
                $display("%0t: last_of_run expected %b actual %b", $time, want.last, last);
            end
            if (want.done !== done) begin
                errors++;
                $display("%0t: string_done expected %b actual %b", $time, want.done, done);
            end
        endfunction

        function int unsigned pending();
            return expected_units.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    unit_ledger  ledger;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_left = 0;
    int unsigned quiet_cycles = 0;
    int unsigned phase_bytes;

    utf8_to_utf16_transcoder u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Receiver: random stalls, plus a long hold-off when requested.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            ledger.check_unit(m_tdata, m_tlast, m_tuser);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no request moved for %0d cycles", $time, quiet_cycles);
                $display("utf8_to_utf16_transcoder: mismatch");
                $finish;
            end
        end
    end

    task automatic send_byte(bit [7:0] data, bit eos);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= eos;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        ledger.note_byte(data, eos);
        phase_bytes++;
    endtask

    function automatic void encode(bit [20:0] cp, int unsigned n, ref bit [7:0] q[$]);
        case (n)
            1: q.insert(q.size(), {1'b0, cp[6:0]});
            2: begin
                q.insert(q.size(), {3'b110, cp[10:6]});
                q.insert(q.size(), {2'b10, cp[5:0]});
            end
            3: begin
                q.insert(q.size(), {4'b1110, cp[15:12]});
                q.insert(q.size(), {2'b10, cp[11:6]});
                q.insert(q.size(), {2'b10, cp[5:0]});
            end
            default: begin
                q.insert(q.size(), {5'b11110, cp[20:18]});
                q.insert(q.size(), {2'b10, cp[17:12]});
                q.insert(q.size(), {2'b10, cp[11:6]});
                q.insert(q.size(), {2'b10, cp[5:0]});
            end
        endcase
    endfunction

    function automatic bit [20:0] legal_point(int unsigned n);
        case (n)
            1: return 21'($urandom_range(32'h7F, 0));
            2: return 21'($urandom_range(32'h7FF, 32'h80));
            3: return 21'($urandom_range(1) ? $urandom_range(32'hD7FF, 32'h800)
                                             : $urandom_range(32'hFFFF, 32'hE000));
            default: return 21'($urandom_range(32'h10FFFF, 32'h10000));
        endcase
    endfunction

    // One string of mostly well-formed characters, with noise and broken sequences mixed in.
    task automatic send_string();
        bit [7:0]    q[$];
        bit [7:0]    part[$];
        int unsigned chars, kind, n, cut, idx;
        chars = $urandom_range(6, 1);
        repeat (chars) begin
            part.delete();
            kind = $urandom_range(99);
            if (kind < 55) begin
                n = $urandom_range(4, 1);
                encode(legal_point(n), n, part);
            end else if (kind < 70) begin
                part.insert(part.size(), 8'($urandom_range(255)));
            end else if (kind < 78) begin
                // truncated sequence
                n = $urandom_range(4, 2);
                encode(legal_point(n), n, part);
                cut = $urandom_range(n - 1, 1);
                repeat (cut) void'(part.pop_back());
            end else if (kind < 86) begin
                // broken continuation
                n = $urandom_range(4, 2);
                encode(legal_point(n), n, part);
                idx = $urandom_range(n - 1, 1);
                part[idx] = 8'($urandom_range(255));
                if (part[idx][7:6] == 2'b10) part[idx][6] = 1'b1;
            end else if (kind < 93) begin
                // overlong form
                n = $urandom_range(4, 2);
                encode(21'($urandom_range(n == 2 ? 32'h7F : n == 3 ? 32'h7FF : 32'hFFFF, 0)),
                       n, part);
            end else if ($urandom_range(1)) begin
                encode(21'($urandom_range(32'hDFFF, 32'hD800)), 3, part);
            end else begin
                encode(21'($urandom_range(32'h1FFFFF, 32'h110000)), 4, part);
            end
            q = {q, part};
        end
        foreach (q[i]) send_byte(q[i], i == q.size() - 1);
    endtask

    // bit 8 marks the end of a string
    bit [8:0] directed_bytes[] = '{
        9'h000, 9'h17F,                      // ASCII extremes
        9'h0C2, 9'h080,                      // smallest two-byte form
        9'h0EF, 9'h0BF, 9'h0BF,              // largest three-byte form
        9'h0F4, 9'h08F, 9'h0BF, 9'h1BF,      // highest code point as a surrogate pair
        9'h080, 9'h0FF,                      // stray continuation and invalid lead
        9'h0C0, 9'h080,                      // overlong
        9'h0ED, 9'h0A0, 9'h080,              // encoded surrogate
        9'h0F4, 9'h090, 9'h080, 9'h080,      // above the code space
        9'h0F0, 9'h090, 9'h080, 9'h141,      // bad continuation after three held bytes
        9'h0E2, 9'h182                       // string ends mid-sequence
    };

    initial begin
        ledger = new();
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_bytes[i]) send_byte(directed_bytes[i][7:0], directed_bytes[i][8]);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            // fill the block against a stalled receiver
            if (phase == 0) hold_left = PRESSURE_CYCLES;
            phase_bytes = 0;
            while (phase_bytes < BYTES_PER_PHASE) send_string();
        end
        s_tvalid <= 1'b0;

        while (ledger.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (ledger.errors == 0)
            $display("utf8_to_utf16_transcoder: match");
        else
            $display("utf8_to_utf16_transcoder: mismatch");
        $finish;
    end
endmodule
